// File: hw/rtl/bknl_pkg.sv
// Shared types, constants and helpers for the bounded k-nearest list.
`timescale 1ns / 1ps
`default_nettype none

package bknl_pkg;

  // List depth and id range
  localparam int MAX_KEEP = 16;
  localparam int ID_SPACE = 65536;

  // Field widths
  localparam int ID_W    = 16;
  localparam int DIST_W  = 32;
  localparam int KEEP_W  = 5;
  localparam int RANK_W  = 4;
  localparam int TOTAL_W = 5;
  localparam int FILL_W  = $clog2(MAX_KEEP + 1);

  // Keep count after reset
  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);

  // Command codes
  localparam logic CMD_OFFER  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // One list entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
  } entry_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_mode_t;

  // Control broadcast along the chain
  typedef struct packed {
    cell_mode_t mode;
    entry_t     cand;
  } cell_ctrl_t;

  // True when a is ranked ahead of b: lower distance, then lower id
  function automatic logic beats(input entry_t a, input entry_t b);
    logic res;
    if (a.distance != b.distance) begin
      res = a.distance < b.distance;
    end else begin
      res = a.id < b.id;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bknl_ifs.sv
// Valid/ready channel interfaces for offer/finish requests and readout results.
`timescale 1ns / 1ps
`default_nettype none

interface bknl_req_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [bknl_pkg::ID_W-1:0]   query_id;
  logic [bknl_pkg::ID_W-1:0]   candidate_id;
  logic [bknl_pkg::DIST_W-1:0] candidate_distance;
  logic                      candidate_live;

  modport source (
    output valid, cmd, query_id, candidate_id, candidate_distance, candidate_live,
    input  ready
  );
  modport sink (
    input  valid, cmd, query_id, candidate_id, candidate_distance, candidate_live,
    output ready
  );
endinterface

interface bknl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bknl_pkg::ID_W-1:0]    near_id;
  logic [bknl_pkg::RANK_W-1:0]  rank;
  logic                         found;
  logic [bknl_pkg::TOTAL_W-1:0] kept_total;
  logic                         last;

  modport source (
    output valid, near_id, rank, found, kept_total, last,
    input  ready
  );
  modport sink (
    input  valid, near_id, rank, found, kept_total, last,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/bknl_cell.sv
// One rank cell of the sorted chain: compare, insert, shift right or drain left.
`timescale 1ns / 1ps
`default_nettype none

module bknl_cell (
  input  wire                   clk,
  input  bknl_pkg::cell_ctrl_t  ctrl,
  input  wire                   occupied,
  input  wire                   beat_left,
  input  bknl_pkg::entry_t      left,
  input  bknl_pkg::entry_t      right,
  output bknl_pkg::entry_t      entry,
  output logic                  beat
);

  // Candidate goes at or before this rank when the slot is empty or it wins
  always_comb begin
    beat = !occupied || bknl_pkg::beats(ctrl.cand, entry);
  end

  // Take the left neighbor when the insert point lies to the left,
  // take the candidate at the insert point, drain toward rank 0 on readout
  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      bknl_pkg::CELL_INSERT: begin
        if (beat_left) begin
          entry <= left;
        end else if (beat) begin
          entry <= ctrl.cand;
        end
      end
      bknl_pkg::CELL_SHIFT: begin
        entry <= right;
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_k_nearest_list.sv
// Top level of the bounded k-nearest list: cell chain, fill count and readout.
//
// Usage:
//   req carries offers (cmd 0) and finishes (cmd 1) with valid/ready; a
//   transaction is taken when both are high. rsp carries readout results the
//   same way. cfg_we/cfg_data write keep_count; the user must do so only while
//   idle, which the block does not enforce. Every cell compares an offer's
//   candidate against its entry in parallel and the chain opens a slot in the
//   same edge, so offers can stream at one per cycle while req.ready is high.
//   An offer gives no result. A finish starts a readout that drains the chain
//   toward rank 0, one result per cycle, max(1, fill) results in all; the
//   first result is loaded into the output register once the finish has set
//   busy. req.ready is low during the readout and rises at the edge that loads
//   the last result. If rsp.ready is low the output register holds its
//   result and the drain pauses; nothing is lost or repeated.
//   Reset (rst, synchronous) empties the list, ends any readout, drops a
//   pending result and sets keep_count to 8. The entries themselves are not
//   cleared: only ranks below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_k_nearest_list (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [bknl_pkg::KEEP_W-1:0]         cfg_data,
  bknl_req_if.sink                           req,
  bknl_rsp_if.source                         rsp
);

  localparam int N      = bknl_pkg::MAX_KEEP;
  localparam int FILL_W = bknl_pkg::FILL_W;

  logic [bknl_pkg::KEEP_W-1:0] keep_count;
  logic [FILL_W-1:0]           keep_sat;
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           fill_next;
  logic [FILL_W-1:0]           total;
  logic [FILL_W-1:0]           cnt;
  logic                        busy;

  bknl_pkg::entry_t     cell_q    [N];
  bknl_pkg::entry_t     left_e    [N];
  bknl_pkg::entry_t     right_e   [N];
  logic [N-1:0]         beat;
  logic [N-1:0]         left_beat;
  logic [N-1:0]         occ;
  bknl_pkg::cell_ctrl_t ctrl;

  logic accept;
  logic offer_ok;
  logic has_room;
  logic hit;
  logic do_insert;
  logic load;
  logic load_last;

  logic                          rsp_valid;
  logic [bknl_pkg::ID_W-1:0]     rsp_id;
  logic [bknl_pkg::RANK_W-1:0]   rsp_rank;
  logic                          rsp_found;
  logic [bknl_pkg::TOTAL_W-1:0]  rsp_total;
  logic                          rsp_last;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= bknl_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      keep_count <= cfg_data;
    end
  end

  // Saturate keep count to the chain length
  always_comb begin
    if (32'(keep_count) > 32'(N)) begin
      keep_sat = FILL_W'(N);
    end else begin
      keep_sat = FILL_W'(keep_count);
    end
  end

  // Mark ranks that hold an entry
  for (genvar i = 0; i < N; i++) begin : g_occ
    assign occ[i] = FILL_W'(i) < fill;
  end

  // Wire the chain neighbors
  for (genvar i = 0; i < N; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign left_e[i]    = cell_q[i];
      assign left_beat[i] = 1'b0;
    end else begin : g_body
      assign left_e[i]    = cell_q[i-1];
      assign left_beat[i] = beat[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_e[i] = cell_q[i];
    end else begin : g_inner
      assign right_e[i] = cell_q[i+1];
    end

    bknl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ[i]),
      .beat_left (left_beat[i]),
      .left      (left_e[i]),
      .right     (right_e[i]),
      .entry     (cell_q[i]),
      .beat      (beat[i])
    );
  end

  // Decide whether an offer enters the list
  always_comb begin
    accept   = req.valid && req.ready;
    offer_ok = req.candidate_live
            && (req.candidate_id != req.query_id)
            && (32'(req.candidate_id) < 32'(bknl_pkg::ID_SPACE))
            && (keep_sat != '0);
    has_room  = fill < keep_sat;
    hit       = |(beat & occ);
    do_insert = accept && (req.cmd == bknl_pkg::CMD_OFFER) && offer_ok
             && (has_room || hit);
  end

  // Readout steps whenever the output register is free
  always_comb begin
    load      = busy && (!rsp_valid || rsp.ready);
    load_last = (total == '0) || (cnt + FILL_W'(1) == total);
  end

  // Drive the chain
  always_comb begin
    ctrl.cand.id       = req.candidate_id;
    ctrl.cand.distance = req.candidate_distance;
    if (do_insert) begin
      ctrl.mode = bknl_pkg::CELL_INSERT;
    end else if (load) begin
      ctrl.mode = bknl_pkg::CELL_SHIFT;
    end else begin
      ctrl.mode = bknl_pkg::CELL_HOLD;
    end
  end

  // Advance the fill count
  always_comb begin
    priority if (do_insert && has_room) begin
      fill_next = fill + FILL_W'(1);
    end else if (load && load_last) begin
      fill_next = '0;
    end else begin
      fill_next = fill;
    end
  end

  // Fill count and readout control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      busy  <= 1'b0;
      total <= '0;
      cnt   <= '0;
    end else begin
      fill <= fill_next;
      if (accept && (req.cmd == bknl_pkg::CMD_FINISH)) begin
        busy  <= 1'b1;
        total <= fill;
        cnt   <= '0;
      end else if (load) begin
        cnt <= cnt + FILL_W'(1);
        if (load_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_found <= total != '0;
      rsp_id    <= (total != '0) ? cell_q[0].id : '0;
      rsp_rank  <= bknl_pkg::RANK_W'(cnt);
      rsp_total <= bknl_pkg::TOTAL_W'(total);
      rsp_last  <= load_last;
    end
  end

  assign req.ready       = !busy;
  assign rsp.valid       = rsp_valid;
  assign rsp.near_id     = rsp_id;
  assign rsp.rank        = rsp_rank;
  assign rsp.found       = rsp_found;
  assign rsp.kept_total  = rsp_total;
  assign rsp.last        = rsp_last;

`ifndef SYNTHESIS
  // Fill never runs past the chain length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(N))
    else $error("fill count exceeds chain length");

  // Fill grows by at most one per cycle, or clears at the end of a readout
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (fill == $past(fill)) || (fill == $past(fill) + FILL_W'(1)) || (fill == '0))
    else $error("fill count jumped");

  // The list is empty once the last result of a readout is loaded
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |=> (fill == '0) && !busy)
    else $error("list not cleared after readout");

  // A result that carries a neighbor has a rank inside the readout
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> (32'(rsp.rank) < 32'(rsp.kept_total)))
    else $error("rank outside readout");
`endif

endmodule

`default_nettype wire
